/* rtl/core/fpars_pkg.sv */
`timescale 1ns / 1ps

package fpars_pkg;

    // Parse phases of the frame state machine
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CMD     = 3'd1,
        PH_LENH    = 3'd2,
        PH_LENL    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    // Event codes reported with every byte
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_DATA   = 3'd1;
    localparam logic [2:0] EV_GOOD   = 3'd2;
    localparam logic [2:0] EV_LENERR = 3'd3;
    localparam logic [2:0] EV_SUMERR = 3'd4;

    // Configuration register indexes
    localparam int          CFG_INDEX_W    = 1;
    localparam int          CFG_DATA_W     = 9;
    localparam logic [0:0]  CFG_SYNC_BYTE  = 1'd0;
    localparam logic [0:0]  CFG_MAX_LENGTH = 1'd1;

    // Register reset values
    localparam logic [7:0] SYNC_RESET       = 8'hAA;
    localparam logic [8:0] MAX_LENGTH_RESET = 9'd256;

    // Saturation value of the held length
    localparam logic [8:0] LENGTH_SAT = 9'h1FF;

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [8:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] event_code;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       payload_last;
        logic [7:0] command_code;
        logic [8:0] frame_length;
    } out_item_t;

endpackage

/* rtl/core/fpars_if.sv */
`timescale 1ns / 1ps

// Valid/ready stream channel carrying one payload per transaction
interface fpars_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/sync_length_xor_frame_parser.sv */
`timescale 1ns / 1ps

// Frame parser for sync / command / 16-bit big-endian length / payload / XOR
// checksum frames. Every received byte yields exactly one event transaction:
// nothing, a payload byte with its index and last mark, frame good, length
// error or checksum error; command and length of the current frame ride along
// with each event. Throughput is one byte per clock while the event side is
// ready; an input register and a result register wrap the combinational state
// update. Errors hold the parser until the configured sync byte is seen.
module sync_length_xor_frame_parser #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    fpars_if.sink                             byte_stream,
    fpars_if.source                           event_stream,
    input  logic                              cfg_write_en,
    input  logic [fpars_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fpars_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    fpars_pkg::cfg_t cfg;

    fpars_if #(.payload_t(fpars_pkg::in_item_t)) staged ();

    fpars_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cfg          (cfg)
    );

    fpars_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .staged      (staged.source)
    );

    fpars_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .staged       (staged.sink),
        .event_stream (event_stream)
    );

endmodule

/* rtl/core/fpars_cfg_regs.sv */
`timescale 1ns / 1ps

// Configuration registers: sync byte and length limit
module fpars_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [fpars_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fpars_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output fpars_pkg::cfg_t                   cfg
);

    fpars_pkg::cfg_t cfg_reg;
    fpars_pkg::cfg_t cfg_next;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                fpars_pkg::CFG_SYNC_BYTE:  cfg_next.sync_byte  = cfg_wdata[7:0];
                fpars_pkg::CFG_MAX_LENGTH: cfg_next.max_length = cfg_wdata[8:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_byte  <= fpars_pkg::SYNC_RESET;
            cfg_reg.max_length <= fpars_pkg::MAX_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/fpars_in_stage.sv */
`timescale 1ns / 1ps

// Input register: captures one received byte per transaction
module fpars_in_stage (
    input  logic clk,
    input  logic rst_n,
    fpars_if.sink   byte_stream,
    fpars_if.source staged
);

    logic                 valid_reg;
    logic                 valid_next;
    fpars_pkg::in_item_t  item_reg;
    logic                 load;

    // Take a new byte whenever the register is empty or drains this cycle
    assign byte_stream.ready = !valid_reg || staged.ready;
    assign load              = byte_stream.valid && byte_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_stream.ready)
        begin
            valid_next = byte_stream.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= byte_stream.payload;
        end
    end

    assign staged.valid   = valid_reg;
    assign staged.payload = item_reg;

endmodule

/* rtl/core/fpars_core.sv */
`timescale 1ns / 1ps

// Frame state machine and result register
module fpars_core #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  fpars_pkg::cfg_t cfg,
    fpars_if.sink           staged,
    fpars_if.source         event_stream
);

    localparam logic [15:0] MAX_PAYLOAD_W = 16'(MAX_PAYLOAD);

    fpars_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]           xor_reg, xor_next;
    logic [7:0]           command_reg, command_next;
    logic [7:0]           len_high_reg, len_high_next;
    logic [8:0]           length_reg, length_next;
    logic [8:0]           count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    fpars_pkg::out_item_t out_item_reg, out_item_next;

    logic        take;
    logic [7:0]  b;
    logic [15:0] rx_len;
    logic [15:0] max16;
    logic [15:0] limit;
    logic [8:0]  count_inc;

    // Result register frees up when empty or taken this cycle
    assign staged.ready = !out_valid_reg || event_stream.ready;
    assign take         = staged.valid && staged.ready;

    assign b         = staged.payload.rx_byte;
    assign rx_len    = {len_high_reg, b};
    assign max16     = {7'd0, cfg.max_length};
    assign limit     = (MAX_PAYLOAD_W < max16) ? MAX_PAYLOAD_W : max16;
    assign count_inc = count_reg + 9'd1;

    // Next state and result for the byte in the input register
    always_comb
    begin
        phase_next     = phase_reg;
        xor_next       = xor_reg;
        command_next   = command_reg;
        len_high_next  = len_high_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;

        if (event_stream.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (take)
        begin
            out_valid_next             = 1'b1;
            out_item_next.event_code   = fpars_pkg::EV_NONE;
            out_item_next.data_byte    = 8'd0;
            out_item_next.byte_index   = 8'd0;
            out_item_next.payload_last = 1'b0;

            unique case (phase_reg)
                fpars_pkg::PH_CMD:
                begin
                    command_next = b;
                    xor_next     = xor_reg ^ b;
                    phase_next   = fpars_pkg::PH_LENH;
                end
                fpars_pkg::PH_LENH:
                begin
                    len_high_next = b;
                    xor_next      = xor_reg ^ b;
                    phase_next    = fpars_pkg::PH_LENL;
                end
                fpars_pkg::PH_LENL:
                begin
                    xor_next    = xor_reg ^ b;
                    length_next = (rx_len > 16'(fpars_pkg::LENGTH_SAT)) ?
                                  fpars_pkg::LENGTH_SAT : rx_len[8:0];
                    if (rx_len > limit)
                    begin
                        phase_next               = fpars_pkg::PH_ERROR;
                        out_item_next.event_code = fpars_pkg::EV_LENERR;
                    end
                    else
                    begin
                        count_next = 9'd0;
                        phase_next = (rx_len == 16'd0) ? fpars_pkg::PH_CHECK
                                                       : fpars_pkg::PH_PAYLOAD;
                    end
                end
                fpars_pkg::PH_PAYLOAD:
                begin
                    out_item_next.event_code = fpars_pkg::EV_DATA;
                    out_item_next.data_byte  = b;
                    out_item_next.byte_index = count_reg[7:0];
                    xor_next                 = xor_reg ^ b;
                    count_next               = count_inc;
                    if (count_inc >= length_reg)
                    begin
                        phase_next                 = fpars_pkg::PH_CHECK;
                        out_item_next.payload_last = 1'b1;
                    end
                end
                fpars_pkg::PH_CHECK:
                begin
                    if (b == xor_reg)
                    begin
                        phase_next               = fpars_pkg::PH_IDLE;
                        out_item_next.event_code = fpars_pkg::EV_GOOD;
                    end
                    else
                    begin
                        phase_next               = fpars_pkg::PH_ERROR;
                        out_item_next.event_code = fpars_pkg::EV_SUMERR;
                    end
                end
                default:
                begin
                    // idle, error and the unused code: hunt for sync
                    if (b == cfg.sync_byte)
                    begin
                        phase_next = fpars_pkg::PH_CMD;
                        xor_next   = b;
                    end
                end
            endcase

            out_item_next.command_code = command_next;
            out_item_next.frame_length = length_next;
        end
    end

    // Control and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= fpars_pkg::PH_IDLE;
            xor_reg       <= 8'd0;
            command_reg   <= 8'd0;
            len_high_reg  <= 8'd0;
            length_reg    <= 9'd0;
            count_reg     <= 9'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            xor_reg       <= xor_next;
            command_reg   <= command_next;
            len_high_reg  <= len_high_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register, no reset
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign event_stream.valid   = out_valid_reg;
    assign event_stream.payload = out_item_reg;

endmodule

/* tb/sync_length_xor_frame_parser_tb.sv */
`timescale 1ns / 1ps

module sync_length_xor_frame_parser_tb;

    localparam int PAYLOAD_CAP   = 256;
    // Leave a margin before touching the registers
    localparam int SETTLE_CYCLES = 6;
    // Around 600 bytes; even with 62% gaps and stalls plus the hold-off a run
    // stays far below this limit, so it only trips on a hang
    localparam int CYCLE_LIMIT   = 300000;

    // Predicts the event transaction for every accepted byte and checks the
    // block's results against it in order
    class frame_event_checker;
        fpars_pkg::phase_t    frame_phase;
        logic [7:0]           sum_acc;
        logic [7:0]           cur_command;
        logic [7:0]           len_msb;
        logic [8:0]           cur_length;
        logic [8:0]           data_count;
        logic [7:0]           cfg_sync;
        logic [8:0]           cfg_max_len;
        fpars_pkg::out_item_t expected_events[$];
        int                   mismatches;
        int                   framed_bytes;
        int                   good_frames;
        int                   data_bytes;
        int                   length_errors;
        int                   sum_errors;

        function new();
            frame_phase   = fpars_pkg::PH_IDLE;
            sum_acc       = '0;
            cur_command   = '0;
            len_msb       = '0;
            cur_length    = '0;
            data_count    = '0;
            cfg_sync      = fpars_pkg::SYNC_RESET;
            cfg_max_len   = fpars_pkg::MAX_LENGTH_RESET;
            mismatches    = 0;
            framed_bytes  = 0;
            good_frames   = 0;
            data_bytes    = 0;
            length_errors = 0;
            sum_errors    = 0;
        endfunction

        function void set_register(logic [fpars_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [fpars_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                fpars_pkg::CFG_SYNC_BYTE:  cfg_sync = val[7:0];
                fpars_pkg::CFG_MAX_LENGTH: cfg_max_len = val;
                default: ;
            endcase
        endfunction

        // Effective limit is the register capped by the payload parameter
        function int length_limit();
            return (cfg_max_len > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(cfg_max_len);
        endfunction

        function void note_byte(logic [7:0] b);
            fpars_pkg::out_item_t ev;
            logic [15:0]          len;
            ev = '0;
            ev.event_code = fpars_pkg::EV_NONE;
            if ((frame_phase != fpars_pkg::PH_IDLE && frame_phase != fpars_pkg::PH_ERROR)
                || b == cfg_sync)
                framed_bytes++;
            case (frame_phase)
                fpars_pkg::PH_CMD:
                begin
                    cur_command = b;
                    sum_acc ^= b;
                    frame_phase = fpars_pkg::PH_LENH;
                end
                fpars_pkg::PH_LENH:
                begin
                    len_msb = b;
                    sum_acc ^= b;
                    frame_phase = fpars_pkg::PH_LENL;
                end
                fpars_pkg::PH_LENL:
                begin
                    len = {len_msb, b};
                    sum_acc ^= b;
                    // held length saturates, the limit test uses all 16 bits
                    cur_length = (len > 16'h01FF) ? fpars_pkg::LENGTH_SAT : len[8:0];
                    if (int'(len) > length_limit())
                    begin
                        frame_phase = fpars_pkg::PH_ERROR;
                        ev.event_code = fpars_pkg::EV_LENERR;
                    end
                    else
                    begin
                        data_count = '0;
                        frame_phase = (len == 16'd0) ? fpars_pkg::PH_CHECK
                                                     : fpars_pkg::PH_PAYLOAD;
                    end
                end
                fpars_pkg::PH_PAYLOAD:
                begin
                    ev.event_code = fpars_pkg::EV_DATA;
                    ev.data_byte  = b;
                    ev.byte_index = data_count[7:0];
                    sum_acc ^= b;
                    data_count = data_count + 9'd1;
                    if (data_count >= cur_length)
                    begin
                        frame_phase = fpars_pkg::PH_CHECK;
                        ev.payload_last = 1'b1;
                    end
                end
                fpars_pkg::PH_CHECK:
                begin
                    if (b == sum_acc)
                    begin
                        frame_phase = fpars_pkg::PH_IDLE;
                        ev.event_code = fpars_pkg::EV_GOOD;
                    end
                    else
                    begin
                        frame_phase = fpars_pkg::PH_ERROR;
                        ev.event_code = fpars_pkg::EV_SUMERR;
                    end
                end
                default:
                begin
                    // idle and error only leave on the sync byte
                    if (b == cfg_sync)
                    begin
                        frame_phase = fpars_pkg::PH_CMD;
                        sum_acc = b;
                    end
                end
            endcase
            ev.command_code = cur_command;
            ev.frame_length = cur_length;
            case (ev.event_code)
                fpars_pkg::EV_DATA:   data_bytes++;
                fpars_pkg::EV_GOOD:   good_frames++;
                fpars_pkg::EV_LENERR: length_errors++;
                fpars_pkg::EV_SUMERR: sum_errors++;
                default: ;
            endcase
            expected_events.push_back(ev);
        endfunction

        function void compare_field(string name, logic [8:0] want, logic [8:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_event(fpars_pkg::out_item_t got);
            fpars_pkg::out_item_t want;
            if (expected_events.size() == 0)
            begin
                $display("%0t: event with nothing expected: expected none, actual code %0h",
                         $time, got.event_code);
                mismatches++;
                return;
            end
            want = expected_events.pop_front();
            compare_field("event_code", 9'(want.event_code), 9'(got.event_code));
            compare_field("data_byte", 9'(want.data_byte), 9'(got.data_byte));
            compare_field("byte_index", 9'(want.byte_index), 9'(got.byte_index));
            compare_field("payload_last", 9'(want.payload_last), 9'(got.payload_last));
            compare_field("command_code", 9'(want.command_code), 9'(got.command_code));
            compare_field("frame_length", want.frame_length, got.frame_length);
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_write_en;
    logic [fpars_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fpars_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_request = 0;
    int cycle_count  = 0;

    frame_event_checker chk;

    fpars_if #(.payload_t(fpars_pkg::in_item_t))  byte_if ();
    fpars_if #(.payload_t(fpars_pkg::out_item_t)) event_if ();

    sync_length_xor_frame_parser #(
        .MAX_PAYLOAD (PAYLOAD_CAP)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_if),
        .event_stream (event_if),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, chk.expected_events.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Transaction monitor: inputs go to the predictor, results get checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_if.valid && byte_if.ready)
                chk.note_byte(byte_if.payload.rx_byte);
            if (event_if.valid && event_if.ready)
                chk.check_event(event_if.payload);
        end
    end

    // Result side: random stalls, plus a counted hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        event_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                event_if.ready <= 1'b0;
                hold_left--;
            end
            else
                event_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            byte_if.valid <= 1'b0;
            @(posedge clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.payload.rx_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!byte_if.ready);
    endtask

    // Header, body_n payload bytes, then optionally the checksum (possibly corrupted)
    task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                              input int body_n, input bit with_sum, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = chk.cfg_sync ^ cmd ^ len[15:8] ^ len[7:0];
        send_byte(chk.cfg_sync);
        send_byte(cmd);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (int i = 0; i < body_n; i++)
        begin
            b = 8'($urandom);
            sum ^= b;
            send_byte(b);
        end
        if (with_sum)
            send_byte(corrupt ? (sum ^ 8'($urandom_range(255, 1))) : sum);
    endtask

    task automatic send_random_frame();
        int          limit;
        int          cap;
        int          roll;
        logic [15:0] len;
        logic [7:0]  cmd;
        limit = chk.length_limit();
        cap   = (limit < 12) ? limit : 12;
        roll  = $urandom_range(99);
        cmd   = 8'($urandom);
        if (roll < 70)
        begin
            // well-formed, mostly with a good checksum
            len = 16'($urandom_range(cap, 0));
            send_frame(cmd, len, int'(len), 1'b1, $urandom_range(99) < 12);
        end
        else if (roll < 80)
        begin
            // over the limit, then some trailing bytes in the error state
            len = $urandom_range(1) ? 16'(limit + 1) : 16'($urandom_range(65535, limit + 1));
            send_frame(cmd, len, 0, 1'b0, 1'b0);
            repeat ($urandom_range(3)) send_byte(8'($urandom));
        end
        else if (roll < 90)
        begin
            // cut short; whatever follows lands mid-frame
            len = 16'($urandom_range(cap, 0));
            send_frame(cmd, len, int'($urandom_range(int'(len), 0)), 1'b0, 1'b0);
        end
        else
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
    endtask

    task automatic run_random(input int n_bytes);
        int start;
        start = chk.framed_bytes;
        while (chk.framed_bytes - start < n_bytes)
            send_random_frame();
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain_events();
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (chk.expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] sync_val, input logic [8:0] max_val);
        cfg_write_en <= 1'b1;
        cfg_index    <= fpars_pkg::CFG_SYNC_BYTE;
        cfg_wdata    <= {1'b0, sync_val};
        @(posedge clk);
        chk.set_register(fpars_pkg::CFG_SYNC_BYTE, {1'b0, sync_val});
        cfg_index    <= fpars_pkg::CFG_MAX_LENGTH;
        cfg_wdata    <= max_val;
        @(posedge clk);
        chk.set_register(fpars_pkg::CFG_MAX_LENGTH, max_val);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        chk = new();
        rst_n                   = 1'b0;
        byte_if.valid           = 1'b0;
        byte_if.payload.rx_byte = '0;
        cfg_write_en            = 1'b0;
        cfg_index               = '0;
        cfg_wdata               = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, no idling: directed cases first
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'hFF, 16'd1, 1, 1'b1, 1'b0);
        send_frame(8'h00, 16'd0, 0, 1'b1, 1'b0);
        send_frame(8'h01, 16'd257, 0, 1'b0, 1'b0);
        send_byte(8'h55);
        send_frame(8'h02, 16'hFFFF, 0, 1'b0, 1'b0);
        send_frame(8'h03, 16'd1, 1, 1'b1, 1'b1);
        run_random(50);
        drain_events();

        // Sync 0x00, short limit, sender gaps
        write_config(8'h00, 9'd5);
        tx_idle_pct  = 62;
        rx_stall_pct = 0;
        run_random(50);
        drain_events();

        // Sync 0xFF, full limit, receiver stalls with a long hold-off up front
        write_config(8'hFF, 9'd256);
        tx_idle_pct  = 0;
        rx_stall_pct = 62;
        hold_request = 40;
        send_frame(8'($urandom), 16'd256, 256, 1'b1, 1'b0);
        run_random(50);
        drain_events();

        // Random sync, zero limit, light gaps on both sides
        write_config(8'($urandom), 9'd0);
        tx_idle_pct  = 10;
        rx_stall_pct = 10;
        run_random(50);
        drain_events();

        // Default sync, limit of one, no idling
        write_config(8'hAA, 9'd1);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_random(50);
        drain_events();

        if (chk.expected_events.size() != 0)
        begin
            $display("%0t: %0d expected events never arrived", $time,
                     chk.expected_events.size());
            chk.mismatches++;
        end
        $display("covered %0d framed bytes over five register settings and idle mixes",
                 chk.framed_bytes);
        $display("%0d good frames, %0d payload bytes, %0d length errors, %0d checksum errors",
                 chk.good_frames, chk.data_bytes, chk.length_errors, chk.sum_errors);
        if (chk.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
